### rtl/iem_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the i2c eeprom master
package iem_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned ErrW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;

  localparam logic [CfgIdxW-1:0] CfgDevAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPhaseTicks = 2'd2;

  localparam logic [6:0] DevAddrReset = 7'd80;
  localparam logic [TickW-1:0] AckTimeoutReset = 16'h1000;
  localparam logic [TickW-1:0] PhaseTicksReset = 16'd100;

  localparam logic [FuncW-1:0] FuncTick = 2'd0;
  localparam logic [FuncW-1:0] FuncWrite = 2'd1;
  localparam logic [FuncW-1:0] FuncRead = 2'd2;
  localparam logic [FuncW-1:0] FuncPoll = 2'd3;

  localparam logic [ErrW-1:0] ErrNone = 3'd0;
  localparam logic [ErrW-1:0] ErrDevAddr = 3'd1;
  localparam logic [ErrW-1:0] ErrWordAddr = 3'd2;
  localparam logic [ErrW-1:0] ErrData = 3'd3;
  localparam logic [ErrW-1:0] ErrReadAddr = 3'd4;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] mem_addr;
    logic [ByteW-1:0] write_data;
    logic             sda_in;
  } tick_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_release;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_data;
    logic [ErrW-1:0]  error_code;
    logic             poll_acked;
  } res_t;

endpackage

### rtl/iem_stream_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one payload
interface iem_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/iem_front.sv
`timescale 1ns / 1ps
// front end: takes ticks and queues them for the bus engine
module iem_front
  import iem_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  iem_stream_if.sink in_s,
  output logic  q_valid_o,
  output tick_t q_data_o,
  input  logic  q_pop_i
);

  tick_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, rd_q;
  logic [QueuePtrW:0]    cnt_q;
  logic                  push;

  assign in_s.ready = (cnt_q != (QueuePtrW+1)'(QueueDepth));
  assign push       = in_s.valid && in_s.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_s.data;
  end

endmodule

### rtl/iem_engine.sv
`timescale 1ns / 1ps
// back end: i2c sequencer, one tick per transaction, registered result
module iem_engine
  import iem_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [6:0]       dev_addr_i,
  input  logic [TickW-1:0] ack_timeout_i,
  input  logic [TickW-1:0] phase_ticks_i,
  input  logic             q_valid_i,
  input  tick_t            q_data_i,
  output logic             q_pop_o,
  iem_stream_if.source     out_s
);

  typedef enum logic [3:0] {
    StIdle, StSa, StSb, StBlo, StBhi, StAlo, StAhi, StRslo,
    StRlo, StRhi, StNlo, StNhi, StPlo, StPhi, StPrel
  } step_e;

  step_e            step_q, step_d;
  logic [3:0]       bit_q, bit_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [TickW-1:0] phase_q, phase_d;
  logic [TickW-1:0] wait_q, wait_d;
  logic [FuncW-1:0] op_q, op_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] data_q, data_d;
  logic [1:0]       stage_q, stage_d;
  logic             sda_q, sda_d;
  logic [ByteW-1:0] rd_q, rd_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic             poll_q, poll_d;
  logic             done;
  logic             ovalid_q;
  res_t             res_q;
  logic             fire;
  logic             low, nlow, ends;
  logic [TickW:0]   len;
  logic [TickW-1:0] plen;

  assign fire    = q_valid_i && (!ovalid_q || out_s.ready);
  assign q_pop_o = fire;
  assign out_s.valid = ovalid_q;
  assign out_s.data  = res_q;

  function automatic logic is_low(step_e s);
    return s == StBlo || s == StAlo || s == StRslo || s == StRlo ||
           s == StNlo || s == StPlo;
  endfunction

  assign low  = is_low(step_q);
  assign plen = (phase_ticks_i == '0) ? TickW'(1) : phase_ticks_i;
  assign len  = {1'b0, plen} + (TickW+1)'(low);
  assign ends = ({1'b0, phase_q} + (TickW+1)'(1)) >= len;

  always_comb begin
    step_d = step_q; bit_d = bit_q; shift_d = shift_q; phase_d = phase_q;
    wait_d = wait_q; op_d = op_q; addr_d = addr_q; data_d = data_q;
    stage_d = stage_q; rd_d = rd_q; err_d = err_q; poll_d = poll_q;
    done = 1'b0;
    case (step_q)
      StIdle: begin
        if (q_data_i.func != FuncTick) begin
          op_d = q_data_i.func; addr_d = q_data_i.mem_addr;
          data_d = q_data_i.write_data; err_d = ErrNone; poll_d = 1'b0;
          shift_d = {dev_addr_i, 1'b0}; stage_d = 2'd0; bit_d = '0;
          wait_d = '0; step_d = StSa; phase_d = '0;
        end
      end
      StAhi: begin
        if (!ends) phase_d = phase_q + 1'b1;
        else if (!q_data_i.sda_in) begin
          phase_d = '0;
          case (stage_q)
            2'd0: begin
              if (op_q == FuncPoll) begin
                poll_d = 1'b1; step_d = StPlo;
              end else begin
                shift_d = addr_q; stage_d = 2'd1; bit_d = '0; step_d = StBlo;
              end
            end
            2'd1: begin
              if (op_q == FuncWrite) begin
                shift_d = data_q; stage_d = 2'd2; bit_d = '0; step_d = StBlo;
              end else begin
                shift_d = {dev_addr_i, 1'b1}; stage_d = 2'd3; bit_d = '0;
                step_d = StRslo;
              end
            end
            2'd3: begin
              bit_d = '0; shift_d = '0; step_d = StRlo;
            end
            default: step_d = StPlo;
          endcase
        end else if (({1'b0, wait_q} + (TickW+1)'(1)) >= {1'b0, ack_timeout_i}) begin
          case (stage_q)
            2'd0: err_d = (op_q == FuncPoll) ? ErrNone : ErrDevAddr;
            2'd1: err_d = ErrWordAddr;
            2'd2: err_d = ErrData;
            default: err_d = ErrReadAddr;
          endcase
          if (op_q == FuncPoll) poll_d = 1'b0;
          step_d = StPlo; phase_d = '0;
        end else wait_d = wait_q + 1'b1;
      end
      default: begin
        if (!ends) phase_d = phase_q + 1'b1;
        else begin
          phase_d = '0;
          case (step_q)
            StSa:  step_d = StSb;
            StSb:  step_d = StBlo;
            StBlo: step_d = StBhi;
            StBhi: begin
              shift_d = {shift_q[ByteW-2:0], 1'b0};
              bit_d = bit_q + 1'b1;
              if (bit_q + 1'b1 >= 4'd8) begin
                wait_d = '0; step_d = StAlo;
              end else step_d = StBlo;
            end
            StAlo:  step_d = StAhi;
            StRslo: step_d = StSa;
            StRlo:  step_d = StRhi;
            StRhi: begin
              shift_d = {shift_q[ByteW-2:0], q_data_i.sda_in};
              bit_d = bit_q + 1'b1;
              if (bit_q + 1'b1 >= 4'd8) begin
                rd_d = shift_d; step_d = StNlo;
              end else step_d = StRlo;
            end
            StNlo: step_d = StNhi;
            StNhi: step_d = StPlo;
            StPlo: step_d = StPhi;
            StPhi: step_d = StPrel;
            StPrel: begin
              done = 1'b1; step_d = StIdle;
            end
            default: step_d = StIdle;
          endcase
        end
      end
    endcase

    nlow = is_low(step_d);
    if (nlow && phase_d == '0) sda_d = sda_q;
    else if (step_d == StSb || step_d == StPlo || step_d == StPhi) sda_d = 1'b0;
    else if (step_d == StBlo || step_d == StBhi) sda_d = shift_d[ByteW-1];
    else sda_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle; bit_q <= '0; shift_q <= '0; phase_q <= '0;
      wait_q <= '0; op_q <= '0; addr_q <= '0; data_q <= '0;
      stage_q <= '0; sda_q <= 1'b1; rd_q <= '0; err_q <= ErrNone;
      poll_q <= 1'b0; ovalid_q <= 1'b0; res_q <= '0;
    end else begin
      if (fire) begin
        step_q <= step_d; bit_q <= bit_d; shift_q <= shift_d;
        phase_q <= phase_d; wait_q <= wait_d; op_q <= op_d;
        addr_q <= addr_d; data_q <= data_d; stage_q <= stage_d;
        sda_q <= sda_d; rd_q <= rd_d; err_q <= err_d; poll_q <= poll_d;
        ovalid_q <= 1'b1;
        res_q.scl_level   <= !nlow;
        res_q.sda_release <= sda_d;
        res_q.busy_res    <= (step_d != StIdle);
        res_q.done_res    <= done;
        res_q.read_data   <= rd_d;
        res_q.error_code  <= err_d;
        res_q.poll_acked  <= poll_d;
      end else if (out_s.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/i2c_eeprom_master_unit.sv
`timescale 1ns / 1ps
// I2C master for a 256-byte EEPROM: byte write, random read and write-completion
// poll. Every input transaction is one bus timer tick and yields one result
// transaction; one tick is taken per clock cycle while the output is not stalled.
// A two-entry queue sits between the input side and the sequencer; the sequencer
// output is registered. An output stall halts it and, with the queue full, the input.
module i2c_eeprom_master_unit
  import iem_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  iem_stream_if.sink          in_s,
  iem_stream_if.source        out_s
);

  logic [6:0]       dev_addr_q;
  logic [TickW-1:0] ack_timeout_q, phase_ticks_q;
  logic             q_valid, q_pop;
  tick_t            q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      ack_timeout_q <= AckTimeoutReset;
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDevAddr:    dev_addr_q    <= cfg_data_i[6:0];
        CfgAckTimeout: ack_timeout_q <= cfg_data_i;
        CfgPhaseTicks: phase_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  iem_front u_front (
    .clk_i, .rst_ni, .in_s,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  iem_engine u_engine (
    .clk_i, .rst_ni,
    .dev_addr_i(dev_addr_q), .ack_timeout_i(ack_timeout_q),
    .phase_ticks_i(phase_ticks_q),
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .out_s
  );

endmodule
